// ===== src/oss_pkg.sv =====
// Shared types, constants and next-state functions for the outward spiral scan generator.
// Depends on nothing; used by oss_step and outward_spiral_scan_generator_unit.
package oss_pkg;

    // Coordinate width.
    localparam int CW = 16;
    localparam logic [CW-1:0] C_ONE = CW'(1);
    localparam logic [CW-1:0] C_ALL_ONES = '1;

    // Configuration register indexes.
    localparam logic [2:0] CFG_START_X       = 3'd0;
    localparam logic [2:0] CFG_START_Y       = 3'd1;
    localparam logic [2:0] CFG_START_HEADING = 3'd2;
    localparam logic [2:0] CFG_BOUND_LEFT    = 3'd3;
    localparam logic [2:0] CFG_BOUND_RIGHT   = 3'd4;
    localparam logic [2:0] CFG_BOUND_TOP     = 3'd5;
    localparam logic [2:0] CFG_BOUND_BOTTOM  = 3'd6;

    // Headings.
    typedef enum logic [1:0] {
        DIR_L = 2'd0,
        DIR_R = 2'd1,
        DIR_U = 2'd2,
        DIR_D = 2'd3
    } t_dir;

    // Move / scheduled jump codes: none, or one plus a heading.
    typedef enum logic [2:0] {
        MV_NONE = 3'd0,
        MV_L    = 3'd1,
        MV_R    = 3'd2,
        MV_U    = 3'd3,
        MV_D    = 3'd4
    } t_mv;

    typedef struct packed {
        logic [CW-1:0] start_x;
        logic [CW-1:0] start_y;
        t_dir          start_heading;
        logic [CW-1:0] bound_left;
        logic [CW-1:0] bound_right;
        logic [CW-1:0] bound_top;
        logic [CW-1:0] bound_bottom;
    } t_cfg;

    typedef struct packed {
        logic [CW-1:0] cur_x;
        logic [CW-1:0] cur_y;
        t_dir          heading;
        logic [CW-1:0] reach_left;
        logic [CW-1:0] reach_right;
        logic [CW-1:0] reach_top;
        logic [CW-1:0] reach_bottom;
        t_mv           pending;
        t_mv           last_move;
        logic          done;
    } t_state;

    typedef struct packed {
        logic [CW-1:0] point_x;
        logic [CW-1:0] point_y;
        logic          point_valid;
        logic          now_finished;
    } t_result;

    // Heading that a scheduled jump code refers to.
    function automatic t_dir mv_to_dir(t_mv m);
        t_dir d;
        case (m)
            MV_L:    d = DIR_L;
            MV_R:    d = DIR_R;
            MV_U:    d = DIR_U;
            MV_D:    d = DIR_D;
            default: d = DIR_L;
        endcase
        return d;
    endfunction

    // Start state: start point clamped into the bounds, raised first, then lowered.
    function automatic t_state load_start(t_cfg c);
        t_state r;
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        x = c.start_x;
        y = c.start_y;
        if (x < c.bound_left) x = c.bound_left;
        if (x > c.bound_right) x = c.bound_right;
        if (y < c.bound_top) y = c.bound_top;
        if (y > c.bound_bottom) y = c.bound_bottom;
        r.cur_x        = x;
        r.cur_y        = y;
        r.reach_left   = x;
        r.reach_right  = x;
        r.reach_top    = y;
        r.reach_bottom = y;
        r.heading      = c.start_heading;
        r.pending      = MV_NONE;
        r.last_move    = MV_NONE;
        r.done         = 1'b0;
        return r;
    endfunction

    // Jump beyond the reached extent on one side, chaining over sides with no room.
    function automatic t_state spiral_jump(t_state s, t_cfg c, t_dir d0);
        t_state r;
        t_dir   d;
        logic   stop;
        logic   full;
        r = s;
        d = d0;
        stop = 1'b0;
        // The extents only change when a hop succeeds, so this holds for every hop.
        full = (c.bound_left == s.reach_left) && (c.bound_right == s.reach_right) &&
               (c.bound_top == s.reach_top) && (c.bound_bottom == s.reach_bottom);
        for (int hop = 0; hop < 4; hop++) begin
            if (!stop) begin
                if (full) begin
                    r.done = 1'b1;
                    stop = 1'b1;
                end else begin
                    r.last_move = MV_NONE;
                    case (d)
                        DIR_L: begin
                            if (c.bound_left < r.reach_left) begin
                                r.reach_left = r.reach_left - C_ONE;
                                r.cur_x = r.reach_left;
                                r.heading = DIR_D;
                                stop = 1'b1;
                            end else begin
                                r.cur_x = r.reach_left;
                                d = DIR_D;
                            end
                        end
                        DIR_D: begin
                            if (r.reach_bottom < c.bound_bottom) begin
                                r.reach_bottom = r.reach_bottom + C_ONE;
                                r.cur_y = r.reach_bottom;
                                r.heading = DIR_R;
                                stop = 1'b1;
                            end else begin
                                r.cur_y = r.reach_bottom;
                                d = DIR_R;
                            end
                        end
                        DIR_R: begin
                            if (r.reach_right < c.bound_right) begin
                                r.reach_right = r.reach_right + C_ONE;
                                r.cur_x = r.reach_right;
                                r.heading = DIR_U;
                                stop = 1'b1;
                            end else begin
                                r.cur_x = r.reach_right;
                                d = DIR_U;
                            end
                        end
                        default: begin
                            if (c.bound_top < r.reach_top) begin
                                r.reach_top = r.reach_top - C_ONE;
                                r.cur_y = r.reach_top;
                                r.heading = DIR_L;
                                stop = 1'b1;
                            end else begin
                                r.cur_y = r.reach_top;
                                d = DIR_L;
                            end
                        end
                    endcase
                end
            end
        end
        // Four sides visited without room: the traversal is over.
        if (!stop) r.done = 1'b1;
        return r;
    endfunction

    // One pixel step in the current heading, with turn and edge handling.
    function automatic t_state spiral_move(t_state s, t_cfg c);
        t_state r;
        logic [CW-1:0] v;
        r = s;
        case (s.heading)
            DIR_L: begin
                v = s.cur_x;
                if (c.bound_left < v) begin
                    v = v - C_ONE;
                    r.cur_x = v;
                    r.last_move = MV_L;
                end
                if (v < r.reach_left) begin
                    r.reach_left = v;
                    r.heading = DIR_D;
                end else if (c.bound_left == v) begin
                    if (r.last_move == MV_L) r.pending = MV_D;
                    else r = spiral_jump(r, c, DIR_D);
                end
            end
            DIR_R: begin
                v = s.cur_x;
                if (v < c.bound_right) begin
                    v = v + C_ONE;
                    r.cur_x = v;
                    r.last_move = MV_R;
                end
                if (r.reach_right < v) begin
                    r.reach_right = v;
                    r.heading = DIR_U;
                end else if (c.bound_right == v) begin
                    if (r.last_move == MV_R) r.pending = MV_U;
                    else r = spiral_jump(r, c, DIR_U);
                end
            end
            DIR_U: begin
                v = s.cur_y;
                if (c.bound_top < v) begin
                    v = v - C_ONE;
                    r.cur_y = v;
                    r.last_move = MV_U;
                end
                if (v < r.reach_top) begin
                    r.reach_top = v;
                    r.heading = DIR_L;
                end else if (c.bound_top == v) begin
                    if (r.last_move == MV_U) r.pending = MV_L;
                    else r = spiral_jump(r, c, DIR_L);
                end
            end
            default: begin
                v = s.cur_y;
                if (v < c.bound_bottom) begin
                    v = v + C_ONE;
                    r.cur_y = v;
                    r.last_move = MV_D;
                end
                if (r.reach_bottom < v) begin
                    r.reach_bottom = v;
                    r.heading = DIR_R;
                end else if (c.bound_bottom == v) begin
                    if (r.last_move == MV_D) r.pending = MV_R;
                    else r = spiral_jump(r, c, DIR_R);
                end
            end
        endcase
        return r;
    endfunction

endpackage

// ===== src/outward_spiral_scan_generator_unit.sv =====
// Outward spiral scan generator: one point per request, registered in the output register.
// Throughput is one request per cycle unless the input is stalled; the state update (restart clamp,
// pixel step and up to four chained edge jumps) is combinational. The input is stalled only while
// a result waits in the output register and the receiver stalls. Synchronous active-low reset restores
// the register reset values and the matching start state (origin, heading left, nothing pending).
module outward_spiral_scan_generator_unit
    import oss_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    // Configuration write port
    input  logic          i_cfg_wr_en,
    input  logic [2:0]    i_cfg_index,
    input  logic [CW-1:0] i_cfg_wdata,
    // Request channel
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  logic          i_restart,
    // Result channel
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output logic [CW-1:0] o_point_x,
    output logic [CW-1:0] o_point_y,
    output logic          o_point_valid,
    output logic          o_now_finished
);

    t_cfg    r_cfg;
    t_state  r_state;
    t_state  n_state;
    t_result n_result;
    t_result r_result;
    logic    r_out_valid;
    logic    in_accept;

    // A new request is taken unless a held result is being stalled.
    assign o_in_stall = r_out_valid & i_out_stall;
    assign in_accept  = i_in_valid & ~o_in_stall;

    oss_step u_step (
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .i_restart(i_restart),
        .o_next   (n_state),
        .o_result (n_result)
    );

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_x       <= '0;
            r_cfg.start_y       <= '0;
            r_cfg.start_heading <= DIR_L;
            r_cfg.bound_left    <= '0;
            r_cfg.bound_right   <= C_ALL_ONES;
            r_cfg.bound_top     <= '0;
            r_cfg.bound_bottom  <= C_ALL_ONES;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_START_X:       r_cfg.start_x       <= i_cfg_wdata;
                CFG_START_Y:       r_cfg.start_y       <= i_cfg_wdata;
                CFG_START_HEADING: r_cfg.start_heading <= t_dir'(i_cfg_wdata[1:0]);
                CFG_BOUND_LEFT:    r_cfg.bound_left    <= i_cfg_wdata;
                CFG_BOUND_RIGHT:   r_cfg.bound_right   <= i_cfg_wdata;
                CFG_BOUND_TOP:     r_cfg.bound_top     <= i_cfg_wdata;
                CFG_BOUND_BOTTOM:  r_cfg.bound_bottom  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Traversal state and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.cur_x        <= '0;
            r_state.cur_y        <= '0;
            r_state.heading      <= DIR_L;
            r_state.reach_left   <= '0;
            r_state.reach_right  <= '0;
            r_state.reach_top    <= '0;
            r_state.reach_bottom <= '0;
            r_state.pending      <= MV_NONE;
            r_state.last_move    <= MV_NONE;
            r_state.done         <= 1'b0;
            r_out_valid          <= 1'b0;
        end else begin
            if (in_accept) begin
                r_state <= n_state;
            end
            if (in_accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload register.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_point_x      = r_result.point_x;
    assign o_point_y      = r_result.point_y;
    assign o_point_valid  = r_result.point_valid;
    assign o_now_finished = r_result.now_finished;

endmodule

// ===== src/oss_step.sv =====
// Combinational step of the spiral scan: optional restart, emitted point, next state.
// Depends on oss_pkg for the state, configuration and result types and step functions.
module oss_step
    import oss_pkg::*;
(
    input  t_cfg    i_cfg,
    input  t_state  i_state,
    input  logic    i_restart,
    output t_state  o_next,
    output t_result o_result
);

    t_state s_start;
    t_state s_work;

    // A restart reloads the clamped start point before the point is emitted.
    always_comb begin
        s_start = i_restart ? load_start(i_cfg) : i_state;
    end

    // Advance: a scheduled jump takes precedence over a normal move.
    always_comb begin
        s_work = s_start;
        if (!s_start.done) begin
            if (s_start.pending != MV_NONE) begin
                s_work.pending = MV_NONE;
                s_work = spiral_jump(s_work, i_cfg, mv_to_dir(s_start.pending));
            end else begin
                s_work = spiral_move(s_start, i_cfg);
            end
        end
    end

    assign o_next                = s_work;
    assign o_result.point_x      = s_start.cur_x;
    assign o_result.point_y      = s_start.cur_y;
    assign o_result.point_valid  = ~s_start.done;
    assign o_result.now_finished = s_work.done;

endmodule
